### rtl/rvbc_pkg.sv
// Shared types, constants and the encoder step table for the rotary volume
// and button control block. No dependencies.
`timescale 1ns / 1ps

package rvbc_pkg;

  // Pin word and hold counter sizing
  localparam int PIN_WORD_BITS   = 16;
  localparam int HOLD_COUNT_BITS = 6;

  // Fixed field widths
  localparam int POS_BITS    = 4;
  localparam int HOLD_S_BITS = 6;
  localparam int VOL_BITS    = 7;
  localparam int CFG_BITS    = 7;
  localparam int CFG_IDX_BITS = 3;

  // Hold count compare width covers both operands
  localparam int CMP_BITS = (HOLD_COUNT_BITS > HOLD_S_BITS) ? HOLD_COUNT_BITS : HOLD_S_BITS;
  localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

  // Reset values
  localparam logic [POS_BITS-1:0]    MUTE_POS_RST   = POS_BITS'(0);
  localparam logic [POS_BITS-1:0]    PLAY_POS_RST   = POS_BITS'(1);
  localparam logic [POS_BITS-1:0]    POWER_POS_RST  = POS_BITS'(2);
  localparam logic [HOLD_S_BITS-1:0] HOLD_S_RST     = HOLD_S_BITS'(5);
  localparam logic [VOL_BITS-1:0]    VOL_LIMIT_RST  = VOL_BITS'(100);
  localparam logic [VOL_BITS-1:0]    VOLUME_RST     = VOL_BITS'(50);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MUTE_POS  = 3'd0,
    CFG_PLAY_POS  = 3'd1,
    CFG_POWER_POS = 3'd2,
    CFG_HOLD_S    = 3'd3,
    CFG_VOL_LIMIT = 3'd4
  } cfg_idx_e;

  // Full-step encoder states
  typedef enum logic [2:0] {
    ST_START     = 3'd0,
    ST_CW_FINAL  = 3'd1,
    ST_CW_BEGIN  = 3'd2,
    ST_CW_NEXT   = 3'd3,
    ST_CCW_BEGIN = 3'd4,
    ST_CCW_FINAL = 3'd5,
    ST_CCW_NEXT  = 3'd6
  } enc_state_e;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_CW   = 2'd1,
    MOVE_CCW  = 2'd2
  } enc_move_e;

  typedef struct packed {
    enc_state_e next;
    enc_move_e  move;
  } enc_step_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [POS_BITS-1:0]    mute_pos;
    logic [POS_BITS-1:0]    play_pos;
    logic [POS_BITS-1:0]    power_pos;
    logic [HOLD_S_BITS-1:0] hold_seconds;
    logic [VOL_BITS-1:0]    volume_limit;
  } cfg_t;

  // One poll word
  typedef struct packed {
    logic                     enc_a;
    logic                     enc_b;
    logic [PIN_WORD_BITS-1:0] pins;
    logic                     tick;
  } poll_t;

  // One result word
  typedef struct packed {
    logic [VOL_BITS-1:0] volume_level;
    logic                volume_event;
    logic                amp_enable;
    logic                play_pause;
    logic                shutdown;
  } result_t;

  // Pin level; positions past the pin word read low
  function automatic logic pin_level(logic [PIN_WORD_BITS-1:0] w, logic [POS_BITS-1:0] pos);
    logic lvl;
    lvl = 1'b0;
    if (int'(pos) < PIN_WORD_BITS) begin
      lvl = w[pos];
    end
    return lvl;
  endfunction

  // Full-step decode table, indexed by state and {b, a}
  function automatic enc_step_t enc_step(enc_state_e st, logic [1:0] ba);
    enc_step_t r;
    r.next = ST_START;
    r.move = MOVE_NONE;
    unique case (st)
      ST_START: begin
        case (ba)
          2'd1:    r.next = ST_CW_BEGIN;
          2'd2:    r.next = ST_CCW_BEGIN;
          default: r.next = ST_START;
        endcase
      end
      ST_CW_FINAL: begin
        case (ba)
          2'd0:    r.next = ST_CW_NEXT;
          2'd2:    r.next = ST_CW_FINAL;
          2'd3:    r.move = MOVE_CW;
          default: r.next = ST_START;
        endcase
      end
      ST_CW_BEGIN: begin
        case (ba)
          2'd0:    r.next = ST_CW_NEXT;
          2'd1:    r.next = ST_CW_BEGIN;
          default: r.next = ST_START;
        endcase
      end
      ST_CW_NEXT: begin
        case (ba)
          2'd0:    r.next = ST_CW_NEXT;
          2'd1:    r.next = ST_CW_BEGIN;
          2'd2:    r.next = ST_CW_FINAL;
          default: r.next = ST_START;
        endcase
      end
      ST_CCW_BEGIN: begin
        case (ba)
          2'd0:    r.next = ST_CCW_NEXT;
          2'd2:    r.next = ST_CCW_BEGIN;
          default: r.next = ST_START;
        endcase
      end
      ST_CCW_FINAL: begin
        case (ba)
          2'd0:    r.next = ST_CCW_NEXT;
          2'd1:    r.next = ST_CCW_FINAL;
          2'd3:    r.move = MOVE_CCW;
          default: r.next = ST_START;
        endcase
      end
      ST_CCW_NEXT: begin
        case (ba)
          2'd0:    r.next = ST_CCW_NEXT;
          2'd1:    r.next = ST_CCW_FINAL;
          2'd2:    r.next = ST_CCW_BEGIN;
          default: r.next = ST_START;
        endcase
      end
      // unused state code falls back to start
      default: r.next = ST_START;
    endcase
    return r;
  endfunction

endpackage

### rtl/rvbc_cfg.sv
// Configuration register file: five registers written through a plain port.
// Depends on rvbc_pkg.
`timescale 1ns / 1ps

module rvbc_cfg import rvbc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [CFG_IDX_BITS-1:0] idx_i,
  input  logic [CFG_BITS-1:0]     wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Address decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_MUTE_POS:  cfg_d.mute_pos     = wdata_i[POS_BITS-1:0];
        CFG_PLAY_POS:  cfg_d.play_pos     = wdata_i[POS_BITS-1:0];
        CFG_POWER_POS: cfg_d.power_pos    = wdata_i[POS_BITS-1:0];
        CFG_HOLD_S:    cfg_d.hold_seconds = wdata_i[HOLD_S_BITS-1:0];
        CFG_VOL_LIMIT: cfg_d.volume_limit = wdata_i[VOL_BITS-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mute_pos     <= MUTE_POS_RST;
      cfg_q.play_pos     <= PLAY_POS_RST;
      cfg_q.power_pos    <= POWER_POS_RST;
      cfg_q.hold_seconds <= HOLD_S_RST;
      cfg_q.volume_limit <= VOL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/rvbc_core.sv
// Per-poll update: encoder decode, volume, button edges and power hold,
// with the state registers. Depends on rvbc_pkg.
`timescale 1ns / 1ps

module rvbc_core import rvbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  poll_t   poll_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  enc_state_e                 enc_state_q, enc_state_d;
  logic [VOL_BITS-1:0]        volume_q, volume_d;
  logic                       amp_on_q, amp_on_d;
  logic                       prev_mute_q, prev_play_q;
  logic [HOLD_COUNT_BITS-1:0] hold_q, hold_d;
  logic                       primed_q;

  enc_step_t           step;
  logic [VOL_BITS:0]   vol_inc;
  logic                mute, play, power;
  logic                pulse;

  assign mute  = pin_level(poll_i.pins, cfg_i.mute_pos);
  assign play  = pin_level(poll_i.pins, cfg_i.play_pos);
  assign power = pin_level(poll_i.pins, cfg_i.power_pos);

  // Encoder and volume
  assign step    = enc_step(enc_state_q, {poll_i.enc_b, poll_i.enc_a});
  assign vol_inc = {1'b0, volume_q} + (VOL_BITS+1)'(1);

  always_comb begin
    enc_state_d = step.next;
    volume_d    = volume_q;
    case (step.move)
      MOVE_CW: begin
        volume_d = (vol_inc > {1'b0, cfg_i.volume_limit}) ? cfg_i.volume_limit
                                                          : vol_inc[VOL_BITS-1:0];
      end
      MOVE_CCW: begin
        if (volume_q != '0) volume_d = volume_q - VOL_BITS'(1);
      end
      default: volume_d = volume_q;
    endcase
  end

  // Button edges, ignored on the priming poll
  always_comb begin
    amp_on_d = amp_on_q;
    pulse    = 1'b0;
    if (primed_q) begin
      if (prev_mute_q && !mute) amp_on_d = ~amp_on_q;
      pulse = !prev_play_q && play;
    end
  end

  // Power hold counter, saturating
  always_comb begin
    hold_d = hold_q;
    if (power) begin
      hold_d = '0;
    end else if (poll_i.tick && (hold_q != HOLD_MAX)) begin
      hold_d = hold_q + HOLD_COUNT_BITS'(1);
    end
  end

  // Result of this poll
  always_comb begin
    result_o.volume_level = volume_d;
    result_o.volume_event = (step.move == MOVE_CW) || (step.move == MOVE_CCW);
    result_o.amp_enable   = amp_on_d;
    result_o.play_pause   = pulse;
    result_o.shutdown     = CMP_BITS'(hold_d) > CMP_BITS'(cfg_i.hold_seconds);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_state_q <= ST_START;
      volume_q    <= VOLUME_RST;
      amp_on_q    <= 1'b0;
      prev_mute_q <= 1'b0;
      prev_play_q <= 1'b0;
      hold_q      <= '0;
      primed_q    <= 1'b0;
    end else if (fire_i) begin
      enc_state_q <= enc_state_d;
      volume_q    <= volume_d;
      amp_on_q    <= amp_on_d;
      prev_mute_q <= mute;
      prev_play_q <= play;
      hold_q      <= hold_d;
      primed_q    <= 1'b1;
    end
  end

endmodule

### rtl/rotary_volume_and_button_control_core.sv
// An accepted poll word passes the input register, then the result register.
// Throughput: one word per cycle while out_stall_i is low; the state update
// for a word is one pass of logic between the input and result registers.
// Reset (async, active low): volume 50, amplifier off, encoder at start,
// config registers to defaults, both pipeline registers empty.
// Top level: input register, update core, result register.
// Depends on rvbc_pkg, rvbc_cfg, rvbc_core.
`timescale 1ns / 1ps

module rotary_volume_and_button_control_core import rvbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_BITS-1:0]      cfg_wdata_i,
  // poll channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     enc_a_i,
  input  logic                     enc_b_i,
  input  logic [PIN_WORD_BITS-1:0] expander_pins_i,
  input  logic                     second_tick_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VOL_BITS-1:0]      volume_level_o,
  output logic                     volume_event_o,
  output logic                     amp_enable_o,
  output logic                     play_pause_o,
  output logic                     shutdown_o
);

  cfg_t    cfg;
  poll_t   in_q;
  logic    in_valid_q;
  result_t res, res_q;
  logic    out_valid_q;
  logic    out_free, fire, in_load;

  rvbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Handshake: result register frees up when taken, input register when fired
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q.enc_a <= enc_a_i;
      in_q.enc_b <= enc_b_i;
      in_q.pins  <= expander_pins_i;
      in_q.tick  <= second_tick_i;
    end
  end

  rvbc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .poll_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign volume_level_o = res_q.volume_level;
  assign volume_event_o = res_q.volume_event;
  assign amp_enable_o   = res_q.amp_enable;
  assign play_pause_o   = res_q.play_pause;
  assign shutdown_o     = res_q.shutdown;

endmodule

### rtl/rvbc_checker.sv
// Port-level checks for the rotary volume and button control top level,
// bound to it below. Depends on rvbc_pkg.
`timescale 1ns / 1ps

module rvbc_checker import rvbc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [VOL_BITS-1:0] volume_level_o,
  input logic                shutdown_o
);

  // A stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(volume_level_o)
                                   && $stable(shutdown_o))
    else $error("stalled result word changed");

  // Input is held off only while the result side is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result side free");

  // No result word appears without an accepted poll word ahead of it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o) ##1 !(in_valid_i && !in_stall_o)
      |=> !$rose(out_valid_o))
    else $error("result word without accepted poll");

endmodule

bind rotary_volume_and_button_control_core rvbc_checker u_rvbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .volume_level_o (volume_level_o),
  .shutdown_o     (shutdown_o)
);
